### rtl/gha_pkg.sv
package gha_pkg;

	localparam int TAG_W = 16;
	localparam int GEN_W = 16;

	// operation codes
	localparam logic [2:0] OP_REGISTER = 3'd0;
	localparam logic [2:0] OP_LOOKUP   = 3'd1;
	localparam logic [2:0] OP_MARK     = 3'd2;
	localparam logic [2:0] OP_FLUSH    = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	// result status codes
	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_FOUND    = 3'd1;
	localparam logic [2:0] ST_INVALID  = 3'd2;
	localparam logic [2:0] ST_ASSIGNED = 3'd3;
	localparam logic [2:0] ST_TFULL    = 3'd4;
	localparam logic [2:0] ST_QFULL    = 3'd5;

	// one slot table entry
	typedef struct packed {
		logic [TAG_W-1:0] owner;
		logic [GEN_W-1:0] gen;
		logic             used;
		logic             marked;
	} gha_slot_t;

endpackage

### rtl/gha_ram.sv
module gha_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/generational_handle_allocator.sv
// channel | signals                                              | beat
// input   | start, busy, op, owner_tag, handle_index,            | start && !busy
//         | handle_generation                                    |
// result  | valid, status, owner, slot_index, slot_generation,   | valid (one cycle)
//         | live_count, last                                     |
// register, clear, unknown ops and out-of-range handles: result in the cycle after the beat
// lookup and mark: one slot memory read, then a write back for a mark of a live handle
// flush: walks each slot below the high-water mark (S_WRD, S_WCHK), then serves each tag
// in S_ASEL if it extends the mark, else in S_ASEL, S_APOP, S_AGEN to pop the free stack (stack then slot read)
// reset clears only counters and control; busy is high while an op is in work
// the receiver cannot stall: each result shows for exactly one cycle
module generational_handle_allocator #(
	parameter int SLOTS         = 256,
	parameter int PENDING_DEPTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                op,
	input  logic [gha_pkg::TAG_W-1:0] owner_tag,
	input  logic [15:0]               handle_index,
	input  logic [gha_pkg::GEN_W-1:0] handle_generation,
	output logic                      valid,
	output logic [2:0]                status,
	output logic [gha_pkg::TAG_W-1:0] owner,
	output logic [7:0]                slot_index,
	output logic [gha_pkg::GEN_W-1:0] slot_generation,
	output logic [8:0]                live_count,
	output logic                      last
);
	import gha_pkg::*;

	localparam int IW  = $clog2(SLOTS);
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int PW  = $clog2(PENDING_DEPTH + 1);
	localparam int PIW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int SW  = $bits(gha_slot_t);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_HCHK = 7'b0000010,
		S_WRD  = 7'b0000100,
		S_WCHK = 7'b0001000,
		S_ASEL = 7'b0010000,
		S_APOP = 7'b0100000,
		S_AGEN = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     hw_q, fd_q, walk_q;
	logic [PW-1:0]     pend_q, tag_q;
	logic [TAG_W-1:0]  pend_tags_q [PENDING_DEPTH];
	logic [2:0]        op_q;
	logic [GEN_W-1:0]  hgen_q;
	logic [IW-1:0]     addr_q;

	logic              slot_we;
	logic [IW-1:0]     slot_waddr, slot_raddr;
	gha_slot_t         slot_wdata, slot_rdata;
	logic [SW-1:0]     slot_rbits;
	logic              fs_we;
	logic [IW-1:0]     fs_waddr, fs_raddr, fs_rdata;

	logic [TAG_W-1:0]  cur_tag;
	logic              fin;
	logic              hit;
	logic [31:0]       hidx32, hw32;

	assign slot_rdata = gha_slot_t'(slot_rbits);
	assign cur_tag    = pend_tags_q[tag_q[PIW-1:0]];
	assign fin        = (PW'(tag_q + 1'b1) == pend_q);
	assign hit        = slot_rdata.used && (slot_rdata.gen == hgen_q);
	assign hidx32     = 32'(handle_index);
	assign hw32       = 32'(hw_q);
	assign busy       = (state_q != S_IDLE);

	gha_ram #(.W(SW), .D(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (SW'(slot_wdata)),
		.raddr (slot_raddr),
		.rdata (slot_rbits)
	);

	gha_ram #(.W(IW), .D(SLOTS)) u_free_ram (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (walk_q[IW-1:0]),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	// memory port control
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = addr_q;
		slot_wdata = '0;
		slot_raddr = handle_index[IW-1:0];
		fs_we      = 1'b0;
		fs_waddr   = fd_q[IW-1:0];
		fs_raddr   = IW'(fd_q - 1'b1);
		case (state_q)
			S_HCHK: begin
				slot_wdata        = slot_rdata;
				slot_wdata.marked = 1'b1;
				slot_we           = (op_q == OP_MARK) && hit;
			end
			S_WRD: begin
				slot_raddr = walk_q[IW-1:0];
			end
			S_WCHK: begin
				slot_waddr = walk_q[IW-1:0];
				slot_wdata = '{owner: '0, gen: GEN_W'(slot_rdata.gen + 1'b1),
					used: 1'b0, marked: 1'b0};
				slot_we    = slot_rdata.used && slot_rdata.marked;
				fs_we      = slot_we;
			end
			S_ASEL: begin
				slot_waddr = hw_q[IW-1:0];
				slot_wdata = '{owner: cur_tag, gen: '0, used: 1'b1, marked: 1'b0};
				slot_we    = (pend_q != '0) && (fd_q == '0) && (hw32 < 32'(SLOTS));
			end
			S_APOP: begin
				slot_raddr = fs_rdata;
			end
			S_AGEN: begin
				slot_wdata = '{owner: cur_tag, gen: slot_rdata.gen, used: 1'b1,
					marked: 1'b0};
				slot_we    = 1'b1;
			end
			default: ;
		endcase
	end

	// pending tag queue
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && op == OP_REGISTER &&
			32'(pend_q) < 32'(PENDING_DEPTH)) begin
			pend_tags_q[pend_q[PIW-1:0]] <= owner_tag;
		end
	end

	// sequencer and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hw_q    <= '0;
			fd_q    <= '0;
			pend_q  <= '0;
			walk_q  <= '0;
			tag_q   <= '0;
			valid   <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q            <= op;
						hgen_q          <= handle_generation;
						addr_q          <= handle_index[IW-1:0];
						status          <= ST_DONE;
						owner           <= '0;
						slot_index      <= '0;
						slot_generation <= '0;
						live_count      <= 9'(hw_q - fd_q);
						last            <= 1'b1;
						case (op)
							OP_REGISTER: begin
								valid <= 1'b1;
								if (32'(pend_q) >= 32'(PENDING_DEPTH)) begin
									status <= ST_QFULL;
								end else begin
									pend_q <= PW'(pend_q + 1'b1);
								end
							end
							OP_LOOKUP, OP_MARK: begin
								if (hidx32 >= hw32) begin
									valid  <= 1'b1;
									status <= ST_INVALID;
								end else begin
									state_q <= S_HCHK;
								end
							end
							OP_FLUSH: begin
								walk_q  <= '0;
								state_q <= S_WRD;
							end
							OP_CLEAR: begin
								valid      <= 1'b1;
								hw_q       <= '0;
								fd_q       <= '0;
								pend_q     <= '0;
								live_count <= '0;
							end
							default: valid <= 1'b1;
						endcase
					end
				end
				S_HCHK: begin
					valid   <= 1'b1;
					state_q <= S_IDLE;
					if (hit) begin
						status <= ST_FOUND;
						owner  <= (op_q == OP_LOOKUP) ? slot_rdata.owner : '0;
					end else begin
						status <= ST_INVALID;
					end
				end
				S_WRD: begin
					if (walk_q >= hw_q) begin
						tag_q   <= '0;
						state_q <= S_ASEL;
					end else begin
						state_q <= S_WCHK;
					end
				end
				S_WCHK: begin
					if (slot_rdata.used && slot_rdata.marked) begin
						fd_q <= CW'(fd_q + 1'b1);
					end
					walk_q  <= CW'(walk_q + 1'b1);
					state_q <= S_WRD;
				end
				S_ASEL: begin
					if (pend_q == '0) begin
						valid      <= 1'b1;
						status     <= ST_DONE;
						owner      <= '0;
						last       <= 1'b1;
						live_count <= 9'(hw_q - fd_q);
						state_q    <= S_IDLE;
					end else if (fd_q != '0) begin
						fd_q    <= CW'(fd_q - 1'b1);
						state_q <= S_APOP;
					end else begin
						valid           <= 1'b1;
						owner           <= cur_tag;
						last            <= fin;
						tag_q           <= PW'(tag_q + 1'b1);
						slot_generation <= '0;
						if (hw32 < 32'(SLOTS)) begin
							status     <= ST_ASSIGNED;
							slot_index <= 8'(32'(hw_q));
							live_count <= 9'(hw_q + 1'b1 - fd_q);
							hw_q       <= CW'(hw_q + 1'b1);
						end else begin
							status     <= ST_TFULL;
							slot_index <= '0;
							live_count <= 9'(hw_q - fd_q);
						end
						if (fin) begin
							pend_q  <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_APOP: begin
					addr_q  <= fs_rdata;
					state_q <= S_AGEN;
				end
				S_AGEN: begin
					valid           <= 1'b1;
					status          <= ST_ASSIGNED;
					owner           <= cur_tag;
					slot_index      <= 8'(32'(addr_q));
					slot_generation <= slot_rdata.gen;
					live_count      <= 9'(hw_q - fd_q);
					last            <= fin;
					tag_q           <= PW'(tag_q + 1'b1);
					if (fin) begin
						pend_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ASEL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/gha_checker.sv
module gha_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       valid,
	input logic [2:0] status,
	input logic [8:0] live_count,
	input logic       last
);
	import gha_pkg::*;

	// a beat that is not the final one leaves the block busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("non-final result while idle");

	// the final result frees the block for the next input beat
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> !busy)
		else $error("final result while busy");

	// an accepted beat gives a result or keeps the block working
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> valid || busy)
		else $error("accepted beat lost");

	// an assignment always leaves at least one live slot
	a_assign_live: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status == ST_ASSIGNED |-> live_count != 9'd0)
		else $error("assignment with no live slot");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.valid      (valid),
	.status     (status),
	.live_count (live_count),
	.last       (last)
);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import gha_pkg::*;

	localparam int N_SLOTS   = 256;
	localparam int N_PENDING = 16;
	localparam int WDOG_MAX  = 8000;

	typedef struct {
		logic [2:0]  status;
		logic [15:0] owner;
		logic [7:0]  slot_index;
		logic [15:0] slot_gen;
		logic [8:0]  live;
		logic        last;
	} result_t;

	// handle table predictor with the queue of expected result beats
	class handle_table_sb;
		logic [15:0] own[N_SLOTS];
		logic [15:0] gen[N_SLOTS];
		bit          used[N_SLOTS];
		bit          marked[N_SLOTS];
		logic [7:0]  fstack[N_SLOTS];
		int          fdepth, hw, pcount;
		logic [15:0] ptags[N_PENDING];
		result_t     pending_res[$];
		int          mismatches, n_results, n_assigned, n_tfull, n_qfull, n_freed;

		function new();
			fdepth = 0; hw = 0; pcount = 0;
			mismatches = 0; n_results = 0; n_assigned = 0;
			n_tfull = 0; n_qfull = 0; n_freed = 0;
		endfunction

		function void push(logic [2:0] st, logic [15:0] ow, logic [7:0] si,
				logic [15:0] sg, logic lst);
			result_t r;
			r.status = st; r.owner = ow; r.slot_index = si; r.slot_gen = sg;
			r.live = 9'(hw - fdepth); r.last = lst;
			pending_res = {pending_res, r};
		endfunction

		function bit handle_ok(logic [15:0] idx, logic [15:0] g);
			if (idx >= hw) return 0;
			if (!used[idx]) return 0;
			return gen[idx] == g;
		endfunction

		// try to pick a live handle for well-formed lookups and marks
		function bit pick_live(output logic [15:0] idx, output logic [15:0] g);
			int k;
			idx = 0; g = 0;
			if (hw == 0) return 0;
			for (k = 0; k < 8; k++) begin
				idx = 16'($urandom_range(hw - 1));
				if (used[idx]) begin
					g = gen[idx];
					return 1;
				end
			end
			return 0;
		endfunction

		function void note(logic [2:0] op, logic [15:0] tag, logic [15:0] idx,
				logic [15:0] g);
			int i, s;
			case (op)
				OP_REGISTER: begin
					if (pcount >= N_PENDING) begin
						n_qfull++;
						push(ST_QFULL, 0, 0, 0, 1);
					end else begin
						ptags[pcount++] = tag;
						push(ST_DONE, 0, 0, 0, 1);
					end
				end
				OP_LOOKUP: begin
					if (handle_ok(idx, g)) push(ST_FOUND, own[idx], 0, 0, 1);
					else push(ST_INVALID, 0, 0, 0, 1);
				end
				OP_MARK: begin
					if (handle_ok(idx, g)) begin
						marked[idx] = 1;
						push(ST_FOUND, 0, 0, 0, 1);
					end else begin
						push(ST_INVALID, 0, 0, 0, 1);
					end
				end
				OP_FLUSH: begin
					// free marked slots in ascending order
					for (i = 0; i < hw; i++) begin
						if (used[i] && marked[i]) begin
							used[i] = 0; marked[i] = 0; own[i] = 0;
							gen[i] = gen[i] + 16'd1;
							n_freed++;
							if (fdepth < N_SLOTS) fstack[fdepth++] = 8'(i);
						end
					end
					if (pcount == 0) begin
						push(ST_DONE, 0, 0, 0, 1);
					end else begin
						// hand out slots to queued tags
						for (i = 0; i < pcount; i++) begin
							if (fdepth > 0) begin
								s = fstack[--fdepth];
							end else if (hw < N_SLOTS) begin
								s = hw++;
								gen[s] = 0;
							end else begin
								n_tfull++;
								push(ST_TFULL, ptags[i], 0, 0, i + 1 == pcount);
								continue;
							end
							own[s] = ptags[i]; used[s] = 1; marked[s] = 0;
							n_assigned++;
							push(ST_ASSIGNED, ptags[i], 8'(s), gen[s], i + 1 == pcount);
						end
						pcount = 0;
					end
				end
				OP_CLEAR: begin
					hw = 0; fdepth = 0; pcount = 0;
					push(ST_DONE, 0, 0, 0, 1);
				end
				default: push(ST_DONE, 0, 0, 0, 1);
			endcase
		endfunction

		function void check(result_t got);
			result_t want;
			n_results++;
			if (pending_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: status %0d owner %h", got.status,
						got.owner);
				return;
			end
			want = pending_res.pop_front();
			if (got.status !== want.status || got.owner !== want.owner ||
					got.slot_index !== want.slot_index || got.slot_gen !== want.slot_gen ||
					got.live !== want.live || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp st %0d own %h idx %0d gen %h live %0d last %b, got st %0d own %h idx %0d gen %h live %0d last %b",
						want.status, want.owner, want.slot_index, want.slot_gen,
						want.live, want.last, got.status, got.owner, got.slot_index,
						got.slot_gen, got.live, got.last);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  op;
	logic [15:0] owner_tag;
	logic [15:0] handle_index;
	logic [15:0] handle_generation;
	logic        valid;
	logic [2:0]  status;
	logic [15:0] owner;
	logic [7:0]  slot_index;
	logic [15:0] slot_generation;
	logic [8:0]  live_count;
	logic        last;

	handle_table_sb sb;
	int             idle_cycles;
	int             n_items;
	bit             accepted;

	generational_handle_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.owner_tag(owner_tag), .handle_index(handle_index),
		.handle_generation(handle_generation), .valid(valid), .status(status),
		.owner(owner), .slot_index(slot_index), .slot_generation(slot_generation),
		.live_count(live_count), .last(last)
	);

	// clock
	initial clk = 0;
	always #5 clk = ~clk;

	// result monitor
	always @(posedge clk) begin
		result_t r;
		if (arst_n && valid) begin
			r.status = status; r.owner = owner; r.slot_index = slot_index;
			r.slot_gen = slot_generation; r.live = live_count; r.last = last;
			sb.check(r);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (accepted || valid) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_MAX) begin
				$display("watchdog expired");
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// idle gap before a beat, mostly short, sometimes long
	task automatic gap();
		int n;
		if ($urandom_range(3) == 0) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
			start <= 0;
			repeat (n) @(negedge clk);
		end
	endtask

	// send one input beat; called and returns at a falling edge
	task automatic send(logic [2:0] o, logic [15:0] tag, logic [15:0] idx,
			logic [15:0] g);
		gap();
		start <= 1;
		op <= o; owner_tag <= tag; handle_index <= idx; handle_generation <= g;
		#1;
		while (busy) @(negedge clk);
		sb.note(o, tag, idx, g);
		n_items++;
		accepted <= 1;
		@(posedge clk);
		#1 accepted <= 0;
		@(negedge clk);
	endtask

	task automatic send_live(logic [2:0] o, bit bad_gen);
		logic [15:0] idx, g;
		if (!sb.pick_live(idx, g)) idx = 16'($urandom);
		if (bad_gen) g = g ^ (16'd1 << $urandom_range(15));
		send(o, 16'($urandom), idx, g);
	endtask

	initial begin
		int i, k, r;
		sb = new();
		idle_cycles = 0; n_items = 0; accepted = 0;
		start = 0; op = 0; owner_tag = 0; handle_index = 0; handle_generation = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes and corner behavior
		send(OP_LOOKUP, 0, 0, 0);
		send(OP_REGISTER, 16'hFFFF, 0, 0);
		send(OP_REGISTER, 16'h0000, 0, 0);
		send(OP_FLUSH, 0, 0, 0);
		send(OP_LOOKUP, 0, 0, 0);
		send(OP_LOOKUP, 0, 1, 16'hFFFF);
		send(OP_LOOKUP, 0, 16'hFFFF, 16'hFFFF);
		send(OP_MARK, 0, 0, 0);
		send(OP_MARK, 0, 0, 0);
		send(OP_LOOKUP, 0, 0, 0);
		send(OP_MARK, 0, 16'hFFFF, 0);
		send(OP_FLUSH, 0, 0, 0);
		send(OP_LOOKUP, 0, 0, 0);
		send(OP_LOOKUP, 0, 0, 1);
		send(OP_REGISTER, 16'h5A5A, 0, 0);
		send(OP_FLUSH, 0, 0, 0);
		send(OP_LOOKUP, 0, 0, 1);
		for (i = 0; i < N_PENDING + 1; i++) send(OP_REGISTER, 16'(i), 0, 0);
		send(OP_FLUSH, 0, 0, 0);
		send(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send(3'd6, 0, 0, 0);
		send(3'd7, 0, 0, 0);
		send(OP_CLEAR, 0, 0, 0);
		send(OP_LOOKUP, 0, 0, 0);

		// fill the table, then one more tag overflows it
		for (k = 0; k < N_SLOTS / N_PENDING; k++) begin
			for (i = 0; i < N_PENDING; i++) send(OP_REGISTER, 16'($urandom), 0, 0);
			send(OP_FLUSH, 0, 0, 0);
		end
		send(OP_REGISTER, 16'($urandom), 0, 0);
		send(OP_FLUSH, 0, 0, 0);
		for (i = 0; i < 6; i++) send_live(OP_MARK, 0);
		send(OP_REGISTER, 16'($urandom), 0, 0);
		send(OP_FLUSH, 0, 0, 0);
		send(OP_CLEAR, 0, 0, 0);

		// short random mix, mostly well-formed handles
		for (i = 0; i < 20; i++) begin
			r = $urandom_range(99);
			if (r < 30) send(OP_REGISTER, 16'($urandom), 16'($urandom), 16'($urandom));
			else if (r < 50) send_live(OP_LOOKUP, $urandom_range(4) == 0);
			else if (r < 68) send_live(OP_MARK, $urandom_range(4) == 0);
			else if (r < 72) send(OP_LOOKUP, 16'($urandom), 16'($urandom), 16'($urandom));
			else if (r < 74) send(OP_MARK, 16'($urandom), 16'($urandom), 16'($urandom));
			else if (r < 92) send(OP_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom));
			else if (r < 94) send(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
			else send(3'($urandom_range(7, 5)), 16'($urandom), 16'($urandom),
				16'($urandom));
		end
		start <= 0;

		// drain
		k = 0;
		while (sb.pending_res.size() != 0 && k < WDOG_MAX) begin
			@(negedge clk);
			k++;
		end
		repeat (20) @(negedge clk);
		if (sb.pending_res.size() != 0) begin
			sb.mismatches++;
			$display("%0d expected result beats never arrived", sb.pending_res.size());
		end

		$display("%0d input beats, %0d result beats, %0d slots assigned, %0d freed",
			n_items, sb.n_results, sb.n_assigned, sb.n_freed);
		$display("table full %0d, queue full %0d, mismatches %0d",
			sb.n_tfull, sb.n_qfull, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
